FILE: rtl/tvs_pkg.sv
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared constants for the trapezoid velocity step: configuration register
// indexes, the time step format and the register reset values.
// ----------------------------------------------------------------------------
package tvs_pkg;

  // Configuration register index
  localparam int CFG_ADDR_W = 1;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  localparam cfg_addr_t CFG_ACCEL_RATE = 1'b0;
  localparam cfg_addr_t CFG_MAX_SPEED  = 1'b1;

  // Time step is unsigned Q0.16
  localparam int TIME_BITS = 16;

  // Reset values at the widest supported data width; cut down to size at use
  localparam int RESET_VAL_W = 48;
  localparam logic [RESET_VAL_W-1:0] ACCEL_RATE_RESET = 48'd65536;  // 1.0
  localparam logic [RESET_VAL_W-1:0] MAX_SPEED_RESET  = 48'd32768;  // 0.5

endpackage

FILE: rtl/trapezoid_velocity_step.sv
// ----------------------------------------------------------------------------
// trapezoid_velocity_step
// One step of a trapezoidal velocity profile. Each input beat carries a time
// step, a position error (position minus target) and the previous velocity;
// each output beat carries the next velocity, saturated to DATA_WIDTH signed
// bits. Wrong-way motion is reversed at accel_rate, motion toward the target
// brakes once (|v| + a*dt)^2 >= 2*a*|error|, otherwise it speeds up clamped
// to +/- max_speed. The block takes one beat per cycle while the output is
// not stalled; each beat passes through five register stages (step product,
// wide partial products, partial sums, square sum, compare and select). A
// stalled output fills the bubbles behind it before in_tready drops. Write
// the configuration only while no beat is in flight.
// ----------------------------------------------------------------------------
module trapezoid_velocity_step #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration write port
  input  logic                                  cfg_we,
  input  tvs_pkg::cfg_addr_t                    cfg_addr,
  input  logic [DATA_WIDTH-1:0]                 cfg_wdata,
  // Input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // tdata: time_step[15:0], position_error, current_velocity, zero pad
  input  logic [((tvs_pkg::TIME_BITS+2*DATA_WIDTH+7)/8)*8-1:0] in_tdata,
  // Output stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // tdata: new_velocity, zero pad
  output logic [((DATA_WIDTH+7)/8)*8-1:0]       out_tdata
);
  import tvs_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int TB    = TIME_BITS;
  localparam int RW    = W + 2;            // exact signed sums
  localparam int SW    = W + 1;            // |v| + d
  localparam int QW    = 2 * SW;           // (|v| + d)^2
  localparam int PW    = 2 * W;            // a * |err|
  localparam int AL    = (W + 1) / 2;      // low half of a and |err|
  localparam int AH    = W - AL;
  localparam int SL    = (SW + 1) / 2;     // low half of |v| + d
  localparam int SH    = SW - SL;
  localparam int OUT_W = ((W + 7) / 8) * 8;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [W-1:0] accel_r;
  logic [W-2:0] max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= ACCEL_RATE_RESET[W-1:0];
      max_r   <= MAX_SPEED_RESET[W-2:0];
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ACCEL_RATE: accel_r <= cfg_wdata;
        CFG_MAX_SPEED:  max_r   <= cfg_wdata[W-2:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage valids and backpressure: a stage moves when the next one has room
  // --------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !out_v_r || out_tready;
  assign rdy4 = !s4_v_r || rdy5;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;

  assign in_tready  = rdy1;
  assign out_tvalid = out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r  <= in_tvalid;
      if (rdy2) s2_v_r  <= s1_v_r;
      if (rdy3) s3_v_r  <= s2_v_r;
      if (rdy4) s4_v_r  <= s3_v_r;
      if (rdy5) out_v_r <= s4_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: unpack, magnitudes, a*dt
  // --------------------------------------------------------------------------
  logic [TB-1:0]  in_dt;
  logic [W-1:0]   in_err, in_vel, a_eff;

  assign in_dt  = in_tdata[TB-1:0];
  assign in_err = in_tdata[TB+W-1:TB];
  assign in_vel = in_tdata[TB+2*W-1:TB+W];
  // zero acceleration counts as one LSB
  assign a_eff  = (accel_r == '0) ? W'(1) : accel_r;

  logic [W+TB-1:0] s1_ad_r;
  logic [W-1:0]    s1_a_r, s1_vel_r, s1_abs_v_r, s1_abs_e_r;
  logic            s1_err_neg_r;

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      s1_ad_r      <= (W+TB)'(a_eff) * (W+TB)'(in_dt);
      s1_a_r       <= a_eff;
      s1_vel_r     <= in_vel;
      s1_abs_v_r   <= in_vel[W-1] ? (~in_vel + W'(1)) : in_vel;
      s1_abs_e_r   <= in_err[W-1] ? (~in_err + W'(1)) : in_err;
      s1_err_neg_r <= in_err[W-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: d, |v|+d, v+/-d, partial products of a*|err|
  // --------------------------------------------------------------------------
  logic [W-1:0]         d_val;
  logic signed [RW-1:0] vel_ext, d_ext;

  assign d_val   = s1_ad_r[W+TB-1:TB];
  assign vel_ext = signed'({{2{s1_vel_r[W-1]}}, s1_vel_r});
  assign d_ext   = signed'({2'b00, d_val});

  logic [SW-1:0]        s2_s_r;
  logic signed [RW-1:0] s2_vpd_r, s2_vmd_r;
  logic [2*AH-1:0]      s2_pp_hh_r;
  logic [AH+AL-1:0]     s2_pp_hl_r, s2_pp_lh_r;
  logic [2*AL-1:0]      s2_pp_ll_r;
  logic                 s2_err_neg_r, s2_v_neg_r, s2_v_pos_r;

  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r) begin
      s2_s_r       <= SW'(s1_abs_v_r) + SW'(d_val);
      s2_vpd_r     <= vel_ext + d_ext;
      s2_vmd_r     <= vel_ext - d_ext;
      s2_pp_hh_r   <= (2*AH)'(s1_a_r[W-1:AL]) * (2*AH)'(s1_abs_e_r[W-1:AL]);
      s2_pp_hl_r   <= (AH+AL)'(s1_a_r[W-1:AL]) * (AH+AL)'(s1_abs_e_r[AL-1:0]);
      s2_pp_lh_r   <= (AH+AL)'(s1_a_r[AL-1:0]) * (AH+AL)'(s1_abs_e_r[W-1:AL]);
      s2_pp_ll_r   <= (2*AL)'(s1_a_r[AL-1:0]) * (2*AL)'(s1_abs_e_r[AL-1:0]);
      s2_err_neg_r <= s1_err_neg_r;
      s2_v_neg_r   <= s1_vel_r[W-1];
      s2_v_pos_r   <= !s1_vel_r[W-1] && (s1_vel_r != '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: partial products of (|v|+d)^2, sum a*|err|, result candidates
  // --------------------------------------------------------------------------
  logic signed [RW-1:0] maxv_ext, nmaxv_ext;
  logic [W-1:0]         vpd_sat, vmd_sat, maxv_w, nmaxv_w, acc_pos, acc_neg;
  logic                 pos_clamp, neg_clamp;

  assign maxv_ext  = signed'({3'b000, max_r});
  assign nmaxv_ext = -maxv_ext;
  assign maxv_w    = maxv_ext[W-1:0];
  assign nmaxv_w   = nmaxv_ext[W-1:0];

  // saturate: the top three bits must agree for the value to fit W bits
  always_comb begin
    if (s2_vpd_r[RW-1:W-1] == '0 || s2_vpd_r[RW-1:W-1] == '1) begin
      vpd_sat = s2_vpd_r[W-1:0];
    end else begin
      vpd_sat = s2_vpd_r[RW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    if (s2_vmd_r[RW-1:W-1] == '0 || s2_vmd_r[RW-1:W-1] == '1) begin
      vmd_sat = s2_vmd_r[W-1:0];
    end else begin
      vmd_sat = s2_vmd_r[RW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
  end

  assign pos_clamp = s2_vpd_r > maxv_ext;
  assign neg_clamp = s2_vmd_r < nmaxv_ext;
  assign acc_pos   = pos_clamp ? maxv_w : vpd_sat;
  assign acc_neg   = neg_clamp ? nmaxv_w : vmd_sat;

  logic [2*SH-1:0]  s3_sq_hh_r;
  logic [SH+SL-1:0] s3_sq_hl_r;
  logic [2*SL-1:0]  s3_sq_ll_r;
  logic [PW-1:0]    s3_p_r;
  logic             s3_wrong_r;
  logic [W-1:0]     s3_wrong_val_r, s3_brake_val_r, s3_acc_val_r;

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      s3_sq_hh_r     <= (2*SH)'(s2_s_r[SW-1:SL]) * (2*SH)'(s2_s_r[SW-1:SL]);
      s3_sq_hl_r     <= (SH+SL)'(s2_s_r[SW-1:SL]) * (SH+SL)'(s2_s_r[SL-1:0]);
      s3_sq_ll_r     <= (2*SL)'(s2_s_r[SL-1:0]) * (2*SL)'(s2_s_r[SL-1:0]);
      s3_p_r         <= (PW'(s2_pp_hh_r) << (2*AL)) + (PW'(s2_pp_hl_r) << AL)
                      + (PW'(s2_pp_lh_r) << AL) + PW'(s2_pp_ll_r);
      // wrong way: moving away from the target (zero velocity never is)
      s3_wrong_r     <= s2_err_neg_r ? s2_v_neg_r : s2_v_pos_r;
      s3_wrong_val_r <= s2_err_neg_r ? vpd_sat : vmd_sat;
      s3_brake_val_r <= s2_err_neg_r ? vmd_sat : vpd_sat;
      s3_acc_val_r   <= s2_err_neg_r ? acc_pos : acc_neg;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: sum (|v|+d)^2
  // --------------------------------------------------------------------------
  logic [QW-1:0] s4_sq_r;
  logic [PW-1:0] s4_p_r;
  logic          s4_wrong_r;
  logic [W-1:0]  s4_wrong_val_r, s4_brake_val_r, s4_acc_val_r;

  always_ff @(posedge clk) begin
    if (rdy4 && s3_v_r) begin
      s4_sq_r        <= (QW'(s3_sq_hh_r) << (2*SL)) + (QW'(s3_sq_hl_r) << (SL+1))
                      + QW'(s3_sq_ll_r);
      s4_p_r         <= s3_p_r;
      s4_wrong_r     <= s3_wrong_r;
      s4_wrong_val_r <= s3_wrong_val_r;
      s4_brake_val_r <= s3_brake_val_r;
      s4_acc_val_r   <= s3_acc_val_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: stop test and final select into the output register
  // --------------------------------------------------------------------------
  logic         brake;
  logic [W-1:0] res_nxt;
  logic [W-1:0] out_vel_r;

  assign brake = s4_sq_r >= QW'({s4_p_r, 1'b0});

  always_comb begin
    priority if (s4_wrong_r) begin
      res_nxt = s4_wrong_val_r;
    end else if (brake) begin
      res_nxt = s4_brake_val_r;
    end else begin
      res_nxt = s4_acc_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && s4_v_r) begin
      out_vel_r <= res_nxt;
    end
  end

  assign out_tdata = OUT_W'(out_vel_r);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accel_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_a_r != '0)
    else $error("effective acceleration is zero");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && !rdy4 |=> s4_v_r)
    else $error("stalled stage 4 item lost");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_tready)
    else $error("pipeline not ready while output register is empty");

  a_accel_limit: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && rdy5 && !s4_wrong_r && !brake
      |=> (signed'(out_vel_r) <= signed'(maxv_w))
       && (signed'(out_vel_r) >= signed'(nmaxv_w)))
    else $error("accelerating result beyond max_speed");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid velocity step testbench
// Streams time step / position error / velocity beats through the block under
// several acceleration and speed-limit settings and idle patterns. A
// scoreboard predicts each next velocity at full precision and checks the
// output beats in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DW        = 32;
  localparam int IN_W      = ((tvs_pkg::TIME_BITS + 2*DW + 7)/8)*8;
  localparam int OUT_W     = ((DW + 7)/8)*8;
  localparam int LATENCY   = 5;
  localparam int MAX_CYCLES = 400000;
  localparam int RAND_PHASES = 8;
  localparam int BEATS_PER_PHASE = 250;

  // Predicts the next velocity and holds the ones still owed by the block
  class velocity_scoreboard;
    logic [DW-1:0]   accel;
    logic [DW-2:0]   speed_limit;
    logic [DW-1:0]   expected_velocity[$];
    int              errors;

    function new();
      accel       = tvs_pkg::ACCEL_RATE_RESET[DW-1:0];
      speed_limit = tvs_pkg::MAX_SPEED_RESET[DW-2:0];
      errors      = 0;
    endfunction

    function void set_reg(tvs_pkg::cfg_addr_t addr, logic [DW-1:0] value);
      case (addr)
        tvs_pkg::CFG_ACCEL_RATE: accel = value;
        tvs_pkg::CFG_MAX_SPEED:  speed_limit = value[DW-2:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_velocity.size();
    endfunction

    // Effective acceleration: zero counts as one LSB
    function logic [DW-1:0] accel_eff();
      return (accel == '0) ? DW'(1) : accel;
    endfunction

    function logic [DW-1:0] next_velocity(logic [15:0] dt, logic signed [DW-1:0] err,
                                          logic signed [DW-1:0] vel);
      logic [DW-1:0]       a;
      logic [47:0]         step_prod;
      logic signed [63:0]  d, v64, e64, vmax, r;
      logic [63:0]         abs_v, abs_e;
      logic [67:0]         stop_sq, brake_lim, speed_sum;
      bit                  braking;
      a         = accel_eff();
      step_prod = 48'(a) * 48'(dt);
      d         = $signed({32'b0, step_prod[47:16]});
      v64       = vel;
      e64       = err;
      abs_v     = (v64 < 0) ? 64'(-v64) : 64'(v64);
      abs_e     = (e64 < 0) ? 64'(-e64) : 64'(e64);
      speed_sum = 68'(abs_v) + 68'(d);
      // stopping distance test, cross-multiplied
      stop_sq   = speed_sum * speed_sum;
      brake_lim = (68'(a) * 68'(abs_e)) << 1;
      braking   = (stop_sq >= brake_lim);
      vmax      = $signed({33'b0, speed_limit});
      if (e64 < 0) begin
        if (v64 < 0)              r = v64 + d;
        else if (braking)         r = v64 - d;
        else if (v64 + d > vmax)  r = vmax;
        else                      r = v64 + d;
      end else begin
        if (v64 > 0)              r = v64 - d;
        else if (braking)         r = v64 + d;
        else if (v64 - d < -vmax) r = -vmax;
        else                      r = v64 - d;
      end
      if (r > 64'sd2147483647)       r = 64'sd2147483647;
      else if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[DW-1:0];
    endfunction

    function void note_input(logic [IN_W-1:0] beat);
      expected_velocity.push_back(next_velocity(beat[15:0], beat[16 +: DW],
                                                beat[16+DW +: DW]));
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    task check_result(logic [OUT_W-1:0] beat);
      logic [DW-1:0] want;
      if (expected_velocity.size() == 0) begin
        report($sformatf("output beat %h with nothing outstanding", beat[DW-1:0]));
      end else begin
        want = expected_velocity.pop_front();
        if (beat[DW-1:0] !== want)
          report($sformatf("new_velocity got %h want %h", beat[DW-1:0], want));
      end
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  tvs_pkg::cfg_addr_t       cfg_addr = tvs_pkg::CFG_ACCEL_RATE;
  logic [DW-1:0]            cfg_wdata = '0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  // tdata: time_step, position_error, current_velocity
  logic [IN_W-1:0]          in_tdata = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  // tdata: new_velocity
  logic [OUT_W-1:0]         out_tdata;

  velocity_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycles = 0;

  trapezoid_velocity_step #(.DATA_WIDTH(DW)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Beat monitor: values seen here are the ones from before the edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic send_beat(input logic [15:0] dt, input logic [DW-1:0] err,
                           input logic [DW-1:0] vel);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {vel, err, dt};
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold off until every outstanding velocity is back, plus pipeline slack
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  // One write, then cfg_we drops low before the next write so back-to-back writes never share a step
  task automatic write_reg(input tvs_pkg::cfg_addr_t addr, input logic [DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(addr, value);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly moderate magnitudes, with full-range and extreme values mixed in
  function automatic logic [DW-1:0] pick_value();
    int k;
    k = $urandom_range(0, 99);
    if (k < 15) return $urandom();
    if (k < 45) return $urandom_range(0, 1 << 20) * (($urandom_range(0, 1) != 0) ? -1 : 1);
    if (k < 55) begin
      case ($urandom_range(0, 4))
        0: return 32'h7FFFFFFF;
        1: return 32'h80000000;
        2: return 32'h0;
        3: return 32'h1;
        default: return 32'hFFFFFFFF;
      endcase
    end
    return $urandom_range(0, 1 << 26) * (($urandom_range(0, 1) != 0) ? -1 : 1);
  endfunction

  initial begin
    logic [15:0]    dt;
    logic [DW-1:0]  err, vel, a;
    logic [67:0]    spd, stop_dist;
    logic [47:0]    prod;
    int             k;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings (a = 1.0, limit = 0.5)
    send_beat(16'd0,     32'd0,          32'd0);
    send_beat(16'hFFFF,  32'hFFFFFFFF,   32'd0);          // target ahead, at rest
    send_beat(16'hFFFF,  32'd1,          32'd0);          // target behind, at rest
    send_beat(16'hFFFF,  32'h7FFFFFFF,   32'h7FFFFFFF);
    send_beat(16'hFFFF,  32'h80000000,   32'h80000000);
    send_beat(16'hFFFF,  32'h80000000,   32'h7FFFFFFF);
    send_beat(16'hFFFF,  32'h7FFFFFFF,   32'h80000000);
    send_beat(16'd6554,  -32'sd655360,   -32'sd65536);    // wrong way, reverse up
    send_beat(16'd6554,  32'sd655360,    32'sd65536);     // wrong way, reverse down
    send_beat(16'd6554,  -32'sd100,      32'sd65536);     // brake moving up
    send_beat(16'd6554,  32'sd100,       -32'sd65536);    // brake moving down
    send_beat(16'hFFFF,  -32'sd65536000, 32'sd30000);     // clamp to +limit
    send_beat(16'hFFFF,  32'sd65536000,  -32'sd30000);    // clamp to -limit
    send_beat(16'd1000,  32'd0,          32'sd65536);     // zero error, moving up
    send_beat(16'd1000,  32'd0,          -32'sd65536);    // zero error, moving down
    send_beat(16'd1,     -32'sd65536,    32'd0);
    send_beat(16'd32768, 32'sd65536,     32'd0);
    drain();

    // Directed: zero acceleration and the widest settings
    write_reg(tvs_pkg::CFG_ACCEL_RATE, 32'd0);
    write_reg(tvs_pkg::CFG_MAX_SPEED,  32'h7FFFFFFF);
    send_beat(16'hFFFF,  32'h80000000,   32'd0);
    send_beat(16'hFFFF,  32'd1,          32'd1);
    send_beat(16'hFFFF,  32'd0,          32'd0);
    drain();
    write_reg(tvs_pkg::CFG_ACCEL_RATE, 32'hFFFFFFFF);
    send_beat(16'hFFFF,  32'h80000000,   32'h7FFFFFFF);
    send_beat(16'hFFFF,  32'h7FFFFFFF,   32'h80000000);
    send_beat(16'hFFFF,  32'h80000000,   32'h80000000);
    drain();

    // Random phases: rotate idle patterns and register settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      case (p)
        0: begin
          write_reg(tvs_pkg::CFG_ACCEL_RATE, 32'd0);
          write_reg(tvs_pkg::CFG_MAX_SPEED,  32'h7FFFFFFF);
        end
        1: begin
          write_reg(tvs_pkg::CFG_ACCEL_RATE, 32'hFFFFFFFF);
          write_reg(tvs_pkg::CFG_MAX_SPEED,  32'd0);
        end
        2: begin
          write_reg(tvs_pkg::CFG_ACCEL_RATE, 32'd1);
          write_reg(tvs_pkg::CFG_MAX_SPEED,  $urandom());
        end
        default: begin
          a = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(1, 1 << 22);
          write_reg(tvs_pkg::CFG_ACCEL_RATE, a);
          write_reg(tvs_pkg::CFG_MAX_SPEED,  $urandom());
        end
      endcase

      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        k   = $urandom_range(0, 99);
        dt  = (k < 10) ? 16'd0 : (k < 20) ? 16'hFFFF : 16'($urandom());
        vel = pick_value();
        err = pick_value();
        // Put the error near the braking threshold for this velocity
        if ($urandom_range(0, 99) < 30) begin
          a    = sb.accel_eff();
          prod = 48'(a) * 48'(dt);
          spd  = 68'(($signed(vel) < 0) ? -$signed(64'($signed(vel))) : 64'(vel))
                 + 68'(prod[47:16]);
          stop_dist = (spd * spd) / (68'(a) << 1);
          if (stop_dist < 68'h7FFFFFF0) begin
            err = 32'(stop_dist) + 32'($urandom_range(0, 2)) - 32'd1;
            if ($urandom_range(0, 1) != 0) err = -err;
          end
        end
        send_beat(dt, err, vel);
        // Occasionally stop feeding until the pipe is empty
        if ($urandom_range(0, 199) == 0) drain();
      end
      drain();
    end

    repeat (4 * LATENCY) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d velocities never came out", sb.pending()));
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
